// File: rtl/core/grammar_token_scanner_core_defines.svh
// Assertion macros shared by the token scanner checkers.
`ifndef GRAMMAR_TOKEN_SCANNER_CORE_DEFINES_SVH
`define GRAMMAR_TOKEN_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GTS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gts_pkg.sv
// Shared token and error codes and queue sizing for the grammar token scanner.
`default_nettype none

package gts_pkg;

  // Token kinds as seen on the result port
  typedef enum logic [2:0] {
    KIND_EOF    = 3'd0,
    KIND_IDENT  = 3'd1,
    KIND_EPS    = 3'd2,
    KIND_OR     = 3'd3,
    KIND_COLON  = 3'd4,
    KIND_SEMI   = 3'd5,
    KIND_QUOTED = 3'd6,
    KIND_ERROR  = 3'd7
  } kind_t;

  // Error kinds; the fourth code is unused
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CHAR  = 2'd1,
    ERR_QUOTE = 2'd2
  } err_t;

  // Entries between scanner and result serialiser (power of two)
  localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// File: rtl/core/gts_front.sv
// Scanner front end: classifies each input word, tracks position and builds result entries.
`default_nettype none

module gts_front
  import gts_pkg::*;
#(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 16,
  localparam int RES_W   = 5 + OFFSET_BITS + 3 * POSITION_BITS,
  localparam int ENTRY_W = 1 + 2 * RES_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire logic               in_mode,
  input  wire logic [7:0]         in_text_byte,
  input  wire logic               q_full,
  output logic                    q_wr,
  output logic [ENTRY_W-1:0]      q_data
);

  localparam int OB = OFFSET_BITS;
  localparam int PB = POSITION_BITS;

  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_E     = 8'h45;

  // Keyword progress: 0..3 matched letters of EPS, KW_MISS once it cannot match
  localparam logic [2:0] KW_FULL = 3'd3;
  localparam logic [2:0] KW_MISS = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE, PH_IDENT, PH_SLASH, PH_COMMENT, PH_QUOTE, PH_DEAD, PH_DONE
  } phase_t;

  function automatic logic [7:0] kw_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h45;
      2'd1:    ch = 8'h50;
      2'd2:    ch = 8'h53;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic logic is_tail(input logic [7:0] ch);
    return is_alpha(ch) || (ch inside {[8'h30:8'h39]}) || (ch == CH_UNDER);
  endfunction

  phase_t          phase_r, phase_nxt;
  logic [OB-1:0]   off_r, off_nxt;
  logic [PB-1:0]   line_r, line_nxt;
  logic [PB-1:0]   col_r, col_nxt;
  logic [OB-1:0]   poff_r, poff_nxt;
  logic [PB-1:0]   pline_r, pline_nxt;
  logic [PB-1:0]   pcol_r, pcol_nxt;
  logic [PB-1:0]   plen_r, plen_nxt;
  logic [2:0]      kw_r, kw_nxt;

  logic            take;
  logic            is_end;
  logic [7:0]      ch;
  logic [PB-1:0]   plen_sat;

  // Between-token decision, shared by the idle phase and identifier end
  logic            idle_v;
  kind_t           idle_kind;
  err_t            idle_err;
  phase_t          idle_phase;
  logic            idle_step;
  logic            idle_mark;
  logic [2:0]      idle_kw;

  // Scan decisions
  logic            use_idle;
  logic            step;
  logic            mark;
  logic            plen_inc;
  logic            r0_v;
  kind_t           r0_kind;
  err_t            r0_err;
  logic [OB-1:0]   r0_off;
  logic [PB-1:0]   r0_len;
  logic [PB-1:0]   r0_line;
  logic [PB-1:0]   r0_col;
  logic            r1_v;
  logic [RES_W-1:0] res0, res1;

  assign take     = in_push & ~q_full;
  assign is_end   = in_mode;
  assign ch       = in_text_byte;
  assign plen_sat = plen_r + PB'(plen_r != '1);

  // Classify a word seen between tokens
  always_comb begin
    idle_v     = 1'b0;
    idle_kind  = KIND_EOF;
    idle_err   = ERR_NONE;
    idle_phase = PH_IDLE;
    idle_step  = 1'b0;
    idle_mark  = 1'b0;
    idle_kw    = kw_r;
    if (is_end) begin
      idle_v     = 1'b1;
      idle_phase = PH_DONE;
    end else if (is_alpha(ch)) begin
      idle_mark  = 1'b1;
      idle_step  = 1'b1;
      idle_kw    = (ch == CH_E) ? 3'd1 : KW_MISS;
      idle_phase = PH_IDENT;
    end else begin
      case (ch)
        CH_BAR: begin
          idle_v    = 1'b1;
          idle_kind = KIND_OR;
          idle_step = 1'b1;
        end
        CH_COLON: begin
          idle_v    = 1'b1;
          idle_kind = KIND_COLON;
          idle_step = 1'b1;
        end
        CH_SEMI: begin
          idle_v    = 1'b1;
          idle_kind = KIND_SEMI;
          idle_step = 1'b1;
        end
        CH_SLASH: begin
          idle_mark  = 1'b1;
          idle_step  = 1'b1;
          idle_phase = PH_SLASH;
        end
        CH_QUOTE: begin
          idle_mark  = 1'b1;
          idle_step  = 1'b1;
          idle_phase = PH_QUOTE;
        end
        CH_SPACE, CH_NL: begin
          idle_step = 1'b1;
        end
        default: begin
          idle_v     = 1'b1;
          idle_kind  = KIND_ERROR;
          idle_err   = ERR_CHAR;
          idle_phase = PH_DEAD;
        end
      endcase
    end
  end

  // Phase handling; the first result is a pending token, an error or an end marker
  always_comb begin
    phase_nxt = phase_r;
    kw_nxt    = kw_r;
    use_idle  = 1'b0;
    step      = 1'b0;
    mark      = 1'b0;
    plen_inc  = 1'b0;
    r0_v      = 1'b0;
    r0_kind   = KIND_EOF;
    r0_err    = ERR_NONE;
    r0_off    = poff_r;
    r0_len    = PB'(1);
    r0_line   = pline_r;
    r0_col    = pcol_r;
    case (phase_r)
      PH_IDLE: begin
        use_idle = 1'b1;
      end
      PH_IDENT: begin
        if (!is_end && is_tail(ch)) begin
          kw_nxt   = (kw_r < KW_FULL && ch == kw_char(kw_r[1:0])) ? kw_r + 3'd1 : KW_MISS;
          plen_inc = 1'b1;
          step     = 1'b1;
        end else begin
          r0_v     = 1'b1;
          r0_kind  = (kw_r == KW_FULL) ? KIND_EPS : KIND_IDENT;
          r0_len   = plen_r;
          use_idle = 1'b1;
        end
      end
      PH_SLASH: begin
        if (!is_end && ch == CH_SLASH) begin
          step      = 1'b1;
          phase_nxt = PH_COMMENT;
        end else begin
          r0_v      = 1'b1;
          r0_kind   = KIND_ERROR;
          r0_err    = ERR_CHAR;
          phase_nxt = PH_DEAD;
        end
      end
      PH_COMMENT: begin
        if (is_end) begin
          r0_v      = 1'b1;
          r0_off    = off_r;
          r0_line   = line_r;
          r0_col    = col_r;
          phase_nxt = PH_DONE;
        end else begin
          step = 1'b1;
          if (ch == CH_NL) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_QUOTE: begin
        if (is_end || ch == CH_NL) begin
          r0_v      = 1'b1;
          r0_kind   = KIND_ERROR;
          r0_err    = ERR_QUOTE;
          phase_nxt = PH_DEAD;
        end else begin
          plen_inc = 1'b1;
          step     = 1'b1;
          if (ch == CH_QUOTE) begin
            r0_v      = 1'b1;
            r0_kind   = KIND_QUOTED;
            r0_len    = plen_sat;
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_DONE: begin
        if (is_end) begin
          r0_v    = 1'b1;
          r0_off  = off_r;
          r0_line = line_r;
          r0_col  = col_r;
        end
      end
      default: begin
      end
    endcase
    if (use_idle) begin
      phase_nxt = idle_phase;
      kw_nxt    = idle_kw;
      step      = idle_step;
      mark      = idle_mark;
    end
  end

  assign r1_v = use_idle & idle_v;

  // Position and pending-token counters, all saturating
  always_comb begin
    off_nxt   = off_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    poff_nxt  = poff_r;
    pline_nxt = pline_r;
    pcol_nxt  = pcol_r;
    plen_nxt  = plen_r;
    if (mark) begin
      poff_nxt  = off_r;
      pline_nxt = line_r;
      pcol_nxt  = col_r;
      plen_nxt  = PB'(1);
    end
    if (plen_inc) begin
      plen_nxt = plen_sat;
    end
    if (step) begin
      off_nxt = off_r + OB'(off_r != '1);
      if (ch == CH_NL) begin
        line_nxt = line_r + PB'(line_r != '1);
        col_nxt  = '0;
      end else begin
        col_nxt = col_r + PB'(col_r != '1);
      end
    end
  end

  // Pack results into one queue entry; the idle result is second when both are present
  assign res0 = {r0_kind, r0_err, r0_off, r0_len, r0_line, r0_col};
  assign res1 = {idle_kind, idle_err, off_r, PB'(1), line_r, col_r};

  always_comb begin
    if (r0_v) begin
      q_data = {r1_v, res1, res0};
    end else begin
      q_data = {1'b0, res1, res1};
    end
  end

  assign q_wr = take & (r0_v | r1_v);

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      off_r   <= '0;
      line_r  <= '0;
      col_r   <= '0;
      poff_r  <= '0;
      pline_r <= '0;
      pcol_r  <= '0;
      plen_r  <= '0;
      kw_r    <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      poff_r  <= poff_nxt;
      pline_r <= pline_nxt;
      pcol_r  <= pcol_nxt;
      plen_r  <= plen_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gts_fifo.sv
// Short entry queue between the scanner and the result serialiser.
`default_nettype none

module gts_fifo
  import gts_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == (AW + 1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rptr_r];

  // Occupancy
  always_comb begin
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + (AW + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (AW + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gts_back.sv
// Result back end: hands out the one or two results of each queue entry, oldest first.
`default_nettype none

module gts_back #(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 16,
  localparam int RES_W   = 5 + OFFSET_BITS + 3 * POSITION_BITS,
  localparam int ENTRY_W = 1 + 2 * RES_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  input  wire logic [ENTRY_W-1:0]       q_data,
  output logic                          q_rd,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic [2:0]                    out_token_kind,
  output logic [1:0]                    out_error_kind,
  output logic [OFFSET_BITS-1:0]        out_start_offset,
  output logic [POSITION_BITS-1:0]      out_token_length,
  output logic [POSITION_BITS-1:0]      out_start_line,
  output logic [POSITION_BITS-1:0]      out_start_column,
  output logic                          out_last
);

  localparam int PB = POSITION_BITS;

  logic             sel_r, sel_nxt;
  logic             two;
  logic             pop_ok;
  logic [RES_W-1:0] res;

  assign two    = q_data[ENTRY_W-1];
  assign res    = sel_r ? q_data[2*RES_W-1:RES_W] : q_data[RES_W-1:0];
  assign pop_ok = out_pop & ~q_empty;

  // Release the entry once its final word is taken
  assign q_rd    = pop_ok & (~two | sel_r);
  assign sel_nxt = pop_ok ? (two & ~sel_r) : sel_r;

  assign out_empty        = q_empty;
  assign out_last         = ~two | sel_r;
  assign out_token_kind   = res[RES_W-1 -: 3];
  assign out_error_kind   = res[RES_W-4 -: 2];
  assign out_start_offset = res[3*PB +: OFFSET_BITS];
  assign out_token_length = res[2*PB +: PB];
  assign out_start_line   = res[PB +: PB];
  assign out_start_column = res[0 +: PB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/grammar_token_scanner_core.sv
// Results: an accepted word's results enter the result queue as the word is taken.
// Throughput: one word per cycle while words yield at most one result each; a word that
// ends an identifier and is a bar, colon, semicolon, end word or bad character yields two,
// which take two pops. The scanner stalls only when the four-entry result queue is full.
// Reset: synchronous, active low; clears position counters, scanner phase and the queue.
`default_nettype none

module grammar_token_scanner_core
  import gts_pkg::*;
#(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic                     in_mode,
  input  wire logic [7:0]               in_text_byte,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic [2:0]                    out_token_kind,
  output logic [1:0]                    out_error_kind,
  output logic [OFFSET_BITS-1:0]        out_start_offset,
  output logic [POSITION_BITS-1:0]      out_token_length,
  output logic [POSITION_BITS-1:0]      out_start_line,
  output logic [POSITION_BITS-1:0]      out_start_column,
  output logic                          out_last
);

  localparam int RES_W   = 5 + OFFSET_BITS + 3 * POSITION_BITS;
  localparam int ENTRY_W = 1 + 2 * RES_W;

  logic               q_wr;
  logic               q_full;
  logic               q_rd;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  assign in_full = q_full;

  // Front: scanner
  gts_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_mode      (in_mode),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_data       (q_wdata)
  );

  // Entry queue
  gts_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // Back: result serialiser
  gts_back #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .q_rd             (q_rd),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_error_kind   (out_error_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// File: rtl/core/gts_checker.sv
// Port-level checker for the grammar token scanner, bound to the top level.
`default_nettype none
`include "grammar_token_scanner_core_defines.svh"

module gts_checker
  import gts_pkg::*;
#(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 16
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_push,
  input wire logic                     in_full,
  input wire logic                     in_mode,
  input wire logic [7:0]               in_text_byte,
  input wire logic                     out_empty,
  input wire logic                     out_pop,
  input wire logic [2:0]               out_token_kind,
  input wire logic [1:0]               out_error_kind,
  input wire logic [OFFSET_BITS-1:0]   out_start_offset,
  input wire logic [POSITION_BITS-1:0] out_token_length,
  input wire logic [POSITION_BITS-1:0] out_start_line,
  input wire logic [POSITION_BITS-1:0] out_start_column,
  input wire logic                     out_last
);

  logic out_take;
  logic err_seen_r, err_seen_nxt;
  logic eof_seen_r, eof_seen_nxt;

  assign out_take     = out_pop & ~out_empty;
  assign err_seen_nxt = err_seen_r | (out_take & (out_token_kind == KIND_ERROR));
  assign eof_seen_nxt = eof_seen_r | (out_take & (out_token_kind == KIND_EOF));

  // Sticky marks of an error or end word having been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      eof_seen_r <= 1'b0;
    end else begin
      err_seen_r <= err_seen_nxt;
      eof_seen_r <= eof_seen_nxt;
    end
  end

  // A waiting word holds while not taken
  `GTS_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_token_kind) && $stable(out_start_offset), "result word changed while stalled")
  // The second word of a pair follows at once
  `GTS_ASSERT_NEXT(a_pair, out_take && !out_last, !out_empty, "second word of a pair missing")
  // Nothing follows an error
  `GTS_ASSERT_IMPL(a_dead, err_seen_r, out_empty, "result after error")
  // Only end words follow an end word
  `GTS_ASSERT_IMPL(a_done, eof_seen_r && !out_empty, out_token_kind == KIND_EOF, "token after end of stream")

  logic unused_ok;
  assign unused_ok = in_push ^ in_full ^ in_mode ^ (^in_text_byte) ^ (^out_error_kind) ^
                     (^out_token_length) ^ (^out_start_line) ^ (^out_start_column);

endmodule

bind grammar_token_scanner_core gts_checker #(
  .OFFSET_BITS   (OFFSET_BITS),
  .POSITION_BITS (POSITION_BITS)
) u_gts_checker (.*);

`default_nettype wire
